// File: design/escc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_pkg
// types, constants and helper functions for the epoch/calendar converter
// ----------------------------------------------------------------------------
package escc_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned EpochYear   = 1970;
	localparam int unsigned YearLow     = 2000;
	localparam int unsigned YearHigh    = 2099;

	// days from 1970-01-01 to 2000-01-01
	localparam int unsigned DaysTo2000  = 10957;
	// days from 1970-01-01 to 2100-01-01
	localparam int unsigned DaysTo2100  = 47482;

	localparam int unsigned DayW = 16;
	localparam int unsigned RemW = 17;

	localparam logic OP_TO_SECS = 1'b0;
	localparam logic OP_TO_CAL  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] seconds_in;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] seconds_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        valid_res;
	} out_beat_t;

	// days before first of month m (1..12) in a common year
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// File: design/escc_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_split
// divides a seconds count into day number and time of day over three stages
// ----------------------------------------------------------------------------
module escc_split
	import escc_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [31:0]     secs,
	output logic [DayW-1:0] days,
	output logic [4:0]      hour,
	output logic [5:0]      minute,
	output logic [5:0]      second
);

	// day estimate by reciprocal: (secs * RecipDay) >> 48, RecipDay = floor(2^48 / 86400) + 1
	localparam logic [32:0] RecipDay = 33'((64'd1 << 48) / 64'(SecsPerDay) + 64'd1);

	logic [64:0]     prod_s1;
	logic [31:0]     secs_s1;
	logic [DayW-1:0] days_s2;
	logic [RemW-1:0] rem_s2;
	logic [DayW-1:0] dq;
	logic [RemW-1:0] rq;
	logic [33:0]     dsec;
	logic [4:0]      hour_s3;
	logic [11:0]     rh_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {33'd0, secs} * {32'd0, RecipDay};
			secs_s1 <= secs;
		end
	end

	always_comb begin
		dq   = prod_s1[48 +: DayW];
		dsec = 34'(dq) * 34'(SecsPerDay);
		rq   = RemW'(34'(secs_s1) - dsec);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rq >= RemW'(SecsPerDay)) begin
				days_s2 <= dq + 1'b1;
				rem_s2  <= rq - RemW'(SecsPerDay);
			end else begin
				days_s2 <= dq;
				rem_s2  <= rq;
			end
		end
	end

	logic [4:0]  hq;
	logic [11:0] rhq;
	always_comb begin
		hq = 5'((32'(rem_s2) * 32'd37283) >> 27);
		rhq = 12'(rem_s2 - RemW'(hq) * RemW'(SecsPerHour));
	end

	logic [DayW-1:0] days_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= days_s2;
			hour_s3 <= hq;
			rh_s3   <= rhq;
		end
	end

	logic [5:0] mq;
	always_comb begin
		mq = 6'((24'(rh_s3) * 24'd2185) >> 17);
	end

	assign days   = days_s3;
	assign hour   = hour_s3;
	assign minute = mq;
	assign second = 6'(rh_s3 - 12'(mq) * 12'(SecsPerMin));

endmodule

// File: design/escc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_date
// turns a day number since 1970 into year, month and day over stages
// ----------------------------------------------------------------------------
module escc_date
	import escc_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [DayW-1:0] days,
	output logic [11:0]     year,
	output logic [3:0]      month,
	output logic [4:0]      day
);

	// shift base to 1968-01-01 (leap) so 4-year groups start with a leap year;
	// 2100 is the only non-leap multiple of four in range
	localparam int unsigned Base68 = 731;

	logic [DayW-1:0] d68;
	logic [DayW-1:0] dd;
	logic            past2100;
	always_comb begin
		d68      = days + DayW'(Base68);
		past2100 = (days >= DayW'(DaysTo2100 + 59));
		// pretend 2100-02-29 exists
		dd       = d68 + DayW'(past2100);
	end

	logic [DayW-1:0] dd_s1;
	always_ff @(posedge clk) begin
		if (en) dd_s1 <= dd;
	end

	// group of 1461 days
	logic [7:0]  grp;
	logic [10:0] gr;
	always_comb begin
		grp = 8'((32'(dd_s1) * 32'd45934) >> 26);
		gr  = 11'(dd_s1 - DayW'(grp) * DayW'(1461));
	end

	logic [7:0]  grp_s2;
	logic [10:0] gr_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			grp_s2 <= grp;
			gr_s2  <= gr;
		end
	end

	logic [1:0] yig;
	logic [8:0] doy;
	logic       lp;
	always_comb begin
		if (gr_s2 < 11'd366) begin
			yig = 2'd0; doy = 9'(gr_s2);
		end else if (gr_s2 < 11'd731) begin
			yig = 2'd1; doy = 9'(gr_s2 - 11'd366);
		end else if (gr_s2 < 11'd1096) begin
			yig = 2'd2; doy = 9'(gr_s2 - 11'd731);
		end else begin
			yig = 2'd3; doy = 9'(gr_s2 - 11'd1096);
		end
		lp = (yig == 2'd0);
	end

	logic [11:0] yr_s3;
	logic [8:0]  doy_s3;
	logic        lp_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			yr_s3  <= 12'd1968 + {grp_s2, 2'b00} + 12'(yig);
			doy_s3 <= doy;
			lp_s3  <= lp;
		end
	end

	logic [3:0] mo;
	logic [8:0] start;
	always_comb begin
		mo = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s3 >= days_before_month(4'(m)) + 9'(lp_s3 && m > 2)) mo = 4'(m);
		end
		start = days_before_month(mo) + 9'(lp_s3 && mo > 4'd2);
	end

	assign year  = yr_s3;
	assign month = mo;
	assign day   = 5'(doy_s3 - start) + 5'd1;

endmodule

// File: design/escc_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escc_encode
// checks calendar fields and forms epoch seconds over three stages
// ----------------------------------------------------------------------------
module escc_encode
	import escc_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  in_beat_t    item,
	output logic [31:0] secs,
	output logic        ok
);

	logic       leap;
	logic [6:0] yoff;
	logic       ok_c;
	always_comb begin
		yoff = 7'(item.year_in - 12'(YearLow));
		leap = (item.year_in[1:0] == 2'b00);
		ok_c = item.year_in >= 12'(YearLow) && item.year_in <= 12'(YearHigh)
			&& item.month_in >= 4'd1 && item.month_in <= 4'd12
			&& item.day_in >= 5'd1 && item.day_in <= month_len(item.month_in, leap)
			&& item.hour_in <= 5'd23 && item.minute_in <= 6'd59
			&& item.second_in <= 6'd59;
	end

	logic [DayW-1:0] days_s1;
	logic [16:0]     tod_s1;
	logic            ok_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			days_s1 <= DayW'(DaysTo2000) + DayW'(yoff) * DayW'(365)
				+ DayW'((yoff + 7'd3) >> 2)
				+ DayW'(days_before_month(item.month_in))
				+ DayW'(leap && item.month_in > 4'd2)
				+ DayW'(item.day_in) - DayW'(1);
			tod_s1 <= 17'(item.hour_in) * 17'(SecsPerHour)
				+ 17'(item.minute_in) * 17'(SecsPerMin) + 17'(item.second_in);
			ok_s1 <= ok_c;
		end
	end

	logic [31:0] dsec_s2;
	logic [16:0] tod_s2;
	logic        ok_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			dsec_s2 <= 32'(days_s1) * 32'(SecsPerDay);
			tod_s2  <= tod_s1;
			ok_s2   <= ok_s1;
		end
	end

	logic [31:0] secs_s3;
	logic        ok_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			secs_s3 <= ok_s2 ? dsec_s2 + 32'(tod_s2) : 32'd0;
			ok_s3   <= ok_s2;
		end
	end

	assign secs = secs_s3;
	assign ok   = ok_s3;

endmodule

// File: design/epoch_seconds_calendar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_converter
// converts between unix seconds and gregorian calendar fields
// ----------------------------------------------------------------------------
// Fully pipelined: one beat may enter every cycle unless the pipeline stalls
// (three stages split seconds into day and time of day, three more turn the
// day number into year, month and day; the encode path is padded to the same
// depth). Back-pressure stalls the whole pipeline, and an output holding
// register frees the last stage. Op 0 checks fields for years 2000 to 2099
// and gives seconds, or valid_res low and zero when a field is out of range;
// op 1 always gives valid calendar fields.
module epoch_seconds_calendar_converter
	import escc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int unsigned Depth = 6;

	logic [Depth-1:0] vld_q;
	logic [Depth-1:0] op_q;
	logic             en;
	logic             out_load;

	assign out_load = !out_valid || out_ready;
	assign en       = !vld_q[Depth-1] || out_load;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) op_q <= {op_q[Depth-2:0], in_data.op};
	end

	logic [DayW-1:0] days;
	logic [4:0]      hour;
	logic [5:0]      minute;
	logic [5:0]      second;

	escc_split u_split (
		.clk    (clk),
		.en     (en),
		.secs   (in_data.seconds_in),
		.days   (days),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	logic [4:0] hour_d [3];
	logic [5:0] min_d  [3];
	logic [5:0] sec_d  [3];
	always_ff @(posedge clk) begin
		if (en) begin
			hour_d[0] <= hour;   min_d[0] <= minute; sec_d[0] <= second;
			hour_d[1] <= hour_d[0]; min_d[1] <= min_d[0]; sec_d[1] <= sec_d[0];
			hour_d[2] <= hour_d[1]; min_d[2] <= min_d[1]; sec_d[2] <= sec_d[1];
		end
	end

	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;

	escc_date u_date (
		.clk   (clk),
		.en    (en),
		.days  (days),
		.year  (year),
		.month (month),
		.day   (day)
	);

	logic [31:0] esecs;
	logic        eok;
	logic [31:0] esecs_d [3];
	logic        eok_d   [3];

	escc_encode u_enc (
		.clk  (clk),
		.en   (en),
		.item (in_data),
		.secs (esecs),
		.ok   (eok)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			esecs_d[0] <= esecs;      eok_d[0] <= eok;
			esecs_d[1] <= esecs_d[0]; eok_d[1] <= eok_d[0];
			esecs_d[2] <= esecs_d[1]; eok_d[2] <= eok_d[1];
		end
	end

	out_beat_t res;
	always_comb begin
		res = '0;
		if (op_q[Depth-1] == OP_TO_CAL) begin
			res.year_out   = year;
			res.month_out  = month;
			res.day_out    = day;
			res.hour_out   = hour_d[2];
			res.minute_out = min_d[2];
			res.second_out = sec_d[2];
			res.valid_res  = 1'b1;
		end else begin
			res.seconds_out = esecs_d[2];
			res.valid_res   = eok_d[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= vld_q[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && vld_q[Depth-1]) out_data <= res;
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the epoch/calendar converter: a directed table of dates, extremes and
// out-of-range fields, then random conversions both ways, each beat compared
// with a behavioral calendar model under random idling on both sides
// ----------------------------------------------------------------------------
module tb
	import escc_pkg::*;
();

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	out_beat_t conv_expected_q[$];
	int        mismatches;

	typedef struct {
		in_beat_t  beat;
		bit        has_exp;
		out_beat_t exp_beat;
	} dir_row_t;

	epoch_seconds_calendar_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic bit is_leap(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned mdays(int unsigned y, int unsigned m);
		int unsigned tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && is_leap(y)) return 29;
		return tbl[m - 1];
	endfunction

	function automatic out_beat_t convert_calendar(in_beat_t b);
		out_beat_t   r;
		int unsigned y, mo, d, days, rem;
		bit          ok;
		r = '0;
		if (b.op == OP_TO_SECS) begin
			y  = b.year_in;
			mo = b.month_in;
			d  = b.day_in;
			ok = y >= YearLow && y <= YearHigh && mo >= 1 && mo <= 12;
			if (ok) ok = d >= 1 && d <= mdays(y, mo);
			if (ok) ok = b.hour_in <= 23 && b.minute_in <= 59 && b.second_in <= 59;
			if (ok) begin
				days = 0;
				for (int unsigned k = EpochYear; k < y; k++) days += is_leap(k) ? 366 : 365;
				for (int unsigned k = 1; k < mo; k++) days += mdays(y, k);
				days += d - 1;
				r.seconds_out = 32'(days * SecsPerDay + b.hour_in * SecsPerHour
					+ b.minute_in * SecsPerMin + b.second_in);
				r.valid_res = 1'b1;
			end
		end else begin
			days = b.seconds_in / SecsPerDay;
			rem  = b.seconds_in % SecsPerDay;
			y    = EpochYear;
			mo   = 1;
			while (days >= (is_leap(y) ? 366 : 365)) begin
				days -= is_leap(y) ? 366 : 365;
				y++;
			end
			while (days >= mdays(y, mo) && mo < 12) begin
				days -= mdays(y, mo);
				mo++;
			end
			r.year_out   = 12'(y);
			r.month_out  = 4'(mo);
			r.day_out    = 5'(days + 1);
			r.hour_out   = 5'(rem / SecsPerHour);
			r.minute_out = 6'((rem % SecsPerHour) / SecsPerMin);
			r.second_out = 6'(rem % SecsPerMin);
			r.valid_res  = 1'b1;
		end
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic in_beat_t cal_beat(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s);
		in_beat_t b;
		b            = '0;
		b.op         = OP_TO_SECS;
		b.seconds_in = $urandom;
		b.year_in    = 12'(y);
		b.month_in   = 4'(mo);
		b.day_in     = 5'(d);
		b.hour_in    = 5'(h);
		b.minute_in  = 6'(mi);
		b.second_in  = 6'(s);
		return b;
	endfunction

	function automatic in_beat_t secs_beat(logic [31:0] s);
		in_beat_t b;
		b            = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom, $urandom}));
		b.op         = OP_TO_CAL;
		b.seconds_in = s;
		return b;
	endfunction

	function automatic in_beat_t random_beat();
		in_beat_t    b;
		int unsigned p, y, mo;
		p = $urandom_range(99);
		if (p < 45) begin
			b = secs_beat($urandom);
		end else if (p < 85) begin
			y  = $urandom_range(YearHigh, YearLow);
			mo = $urandom_range(12, 1);
			b  = cal_beat(y, mo, $urandom_range(mdays(y, mo), 1), $urandom_range(23),
				$urandom_range(59), $urandom_range(59));
		end else begin
			b    = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom, $urandom}));
			b.op = OP_TO_SECS;
			if ($urandom_range(1)) b.year_in = 12'($urandom_range(2101, 1998));
		end
		return b;
	endfunction

	task automatic send_beat(in_beat_t b);
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		conv_expected_q.push_back(convert_calendar(b));
		@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if ($urandom_range(199) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(40, 10)) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) < 8) ? 1'b0 : ($urandom_range(3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (conv_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", out_data);
			end else begin
				e = conv_expected_q.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data);
				end
			end
		end
	end

	initial begin
		dir_row_t    dir_rows[$];
		dir_row_t    row;
		out_beat_t   z;
		int unsigned wait_cnt;
		z = '0;
		z.valid_res = 1'b1;
		mismatches = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;

		row.has_exp = 1;
		row.beat = secs_beat(32'd0);
		row.exp_beat = z; row.exp_beat.year_out = 12'd1970; row.exp_beat.month_out = 4'd1;
		row.exp_beat.day_out = 5'd1; dir_rows.push_back(row);
		row.beat = secs_beat(32'hFFFF_FFFF);
		row.exp_beat = z; row.exp_beat.year_out = 12'd2106; row.exp_beat.month_out = 4'd2;
		row.exp_beat.day_out = 5'd7; row.exp_beat.hour_out = 5'd6;
		row.exp_beat.minute_out = 6'd28;
		row.exp_beat.second_out = 6'd15; dir_rows.push_back(row);
		row.beat = cal_beat(2000, 1, 1, 0, 0, 0);
		row.exp_beat = '0; row.exp_beat.seconds_out = 32'd946684800;
		row.exp_beat.valid_res = 1'b1;
		dir_rows.push_back(row);
		row.exp_beat = '0;
		row.beat = cal_beat(1999, 12, 31, 23, 59, 59); dir_rows.push_back(row);
		row.beat = cal_beat(2100, 1, 1, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(4095, 15, 31, 31, 63, 63); dir_rows.push_back(row);
		row.beat = cal_beat(0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2001, 2, 29, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 4, 31, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 13, 1, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 5, 0, 0, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 5, 5, 24, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 5, 5, 0, 60, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2020, 5, 5, 0, 0, 60); dir_rows.push_back(row);
		row.has_exp = 0;
		row.beat = cal_beat(2000, 2, 29, 12, 0, 0); dir_rows.push_back(row);
		row.beat = cal_beat(2099, 12, 31, 23, 59, 59); dir_rows.push_back(row);
		row.beat = cal_beat(2024, 2, 29, 1, 2, 3); dir_rows.push_back(row);
		row.beat = secs_beat(32'd951782400); dir_rows.push_back(row);
		row.beat = secs_beat(32'd4102444800); dir_rows.push_back(row);
		row.beat = secs_beat(32'd4107542399); dir_rows.push_back(row);
		row.beat = secs_beat(32'h7FFF_FFFF); dir_rows.push_back(row);
		row.beat = secs_beat(32'h8000_0000); dir_rows.push_back(row);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp
					&& convert_calendar(dir_rows[i].beat) !== dir_rows[i].exp_beat) begin
				mismatches++;
				if (mismatches <= 10) $display("model disagrees on row %0d", i);
			end
			send_beat(dir_rows[i].beat);
		end

		for (int n = 0; n < 650; n++) begin
			if (n == 300) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (conv_expected_q.size() != 0) @(negedge clk);
			end
			send_beat(random_beat());
		end
		in_valid <= 1'b0;

		wait_cnt = 0;
		while (conv_expected_q.size() != 0 && wait_cnt < 100000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (20) @(negedge clk);
		if (mismatches == 0 && conv_expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: epoch_seconds_calendar_converter.f
design/escc_pkg.sv
design/escc_split.sv
design/escc_date.sv
design/escc_encode.sv
design/epoch_seconds_calendar_converter.sv
dv/tb.sv
